>>> src/atpb_pkg.sv
// shared types and constants for the alpha template pixel blend
package atpb_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned QueueDepth    = 2;

   localparam logic [CsrIndexWidth-1:0] RegDrawMode    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegInvertAlpha = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegFgColor     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegBgColor     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegPixelFormat = 3'd4;

   localparam logic [1:0] ModeTransparent = 2'd0;
   localparam logic [1:0] ModeInvert      = 2'd1;
   localparam logic [1:0] ModeOpaque      = 2'd2;

   localparam logic FormatXrgb8888 = 1'b0;
   localparam logic FormatRgb565   = 1'b1;

   // what the back end has to do with a pixel
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_FG,
      KIND_BLEND,
      KIND_INVERT,
      KIND_MIX
   } kind_type;

   typedef struct packed {
      logic [1:0]  draw_mode;
      logic        invert_alpha;
      logic [23:0] fg_color;
      logic [23:0] bg_color;
      logic        pixel_format;
   } cfg_type;

   // classified pixel handed from front end to back end
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  alpha;
      logic [7:0]  dst_r;
      logic [7:0]  dst_g;
      logic [7:0]  dst_b;
      logic [31:0] dest;
   } item_type;

   function automatic logic [31:0] pack_pixel(logic fmt, logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b);
      logic [31:0] px;
      if (fmt == FormatRgb565) begin
         px = {16'h0000, r[7:3], g[7:2], b[7:3]};
      end else begin
         px = {8'h00, r, g, b};
      end
      return px;
   endfunction

endpackage

>>> src/atpb_front.sv
// front end: takes a pixel transaction, applies alpha flip, classifies it
module atpb_front (
   input  logic                start,
   input  logic                queue_full,
   input  logic [7:0]          req_alpha,
   input  logic [31:0]         req_dest_pixel,
   input  atpb_pkg::cfg_type   cfg,
   output logic                busy,
   output logic                push,
   output atpb_pkg::item_type  push_item
);
   import atpb_pkg::*;

   logic [7:0] alpha_eff;
   kind_type   kind;

   assign busy = queue_full;
   assign push = start & ~queue_full;

   assign alpha_eff = req_alpha ^ {8{cfg.invert_alpha}};

   always_comb begin
      case (cfg.draw_mode)
         ModeTransparent: begin
            if (alpha_eff == 8'hff) begin
               kind = KIND_FG;
            end else if (alpha_eff != 8'h00) begin
               kind = KIND_BLEND;
            end else begin
               kind = KIND_NONE;
            end
         end
         ModeInvert: kind = alpha_eff[7] ? KIND_INVERT : KIND_NONE;
         ModeOpaque: kind = KIND_MIX;
         default:    kind = KIND_NONE;
      endcase
   end

   always_comb begin
      push_item.kind  = kind;
      push_item.alpha = alpha_eff;
      push_item.dest  = req_dest_pixel;
      // rgb565 channels are widened by shifting, no bit replication
      if (cfg.pixel_format == FormatRgb565) begin
         push_item.dst_r = {req_dest_pixel[15:11], 3'b000};
         push_item.dst_g = {req_dest_pixel[10:5], 2'b00};
         push_item.dst_b = {req_dest_pixel[4:0], 3'b000};
      end else begin
         push_item.dst_r = req_dest_pixel[23:16];
         push_item.dst_g = req_dest_pixel[15:8];
         push_item.dst_b = req_dest_pixel[7:0];
      end
   end

endmodule

>>> src/atpb_queue.sv
// short queue of classified pixels between front and back end
module atpb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  atpb_pkg::item_type  push_item,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output atpb_pkg::item_type  head_item
);
   import atpb_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   item_type                mem_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]       count_ff, count_in;
   logic                    do_pop;

   assign full      = (count_ff == (PtrWidth+1)'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/atpb_back.sv
// back end: per-channel multiply stage, then rounding, pack and result register
module atpb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  atpb_pkg::item_type  head_item,
   input  atpb_pkg::cfg_type   cfg,
   output logic                pop,
   output logic                rsp_valid,
   output logic                rsp_write_enable,
   output logic [31:0]         rsp_new_pixel
);
   import atpb_pkg::*;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        base_r;
      logic [7:0]        base_g;
      logic [7:0]        base_b;
      logic signed [18:0] prod_r;
      logic signed [18:0] prod_g;
      logic signed [18:0] prod_b;
      logic [31:0]       dest;
   } mul_type;

   mul_type     mul_ff, mul_in;
   logic        mul_valid_ff;
   logic        rsp_valid_ff;
   logic        we_ff, we_in;
   logic [31:0] px_ff, px_in;
   logic [7:0]  ch_r, ch_g, ch_b;

   // the receiver cannot stall, so the head is taken every cycle it is there
   assign pop = head_valid;

   function automatic logic signed [18:0] chan_mul(logic [7:0] fg, logic [7:0] base,
                                                   logic [7:0] a);
      logic signed [9:0] diff;
      diff = $signed({2'b00, fg}) - $signed({2'b00, base});
      return 19'(diff) * 19'($signed({1'b0, a}));
   endfunction

   // blend: floor((p*257 + 32768) / 65536); mix: p / 256 toward zero
   function automatic logic [7:0] chan_fin(logic blend, logic [7:0] base,
                                           logic signed [18:0] p);
      logic signed [27:0] wide;
      logic signed [27:0] quo;
      wide = 28'(p);
      if (blend) begin
         quo = ((wide <<< 8) + wide + 28'sd32768) >>> 16;
      end else begin
         quo = (wide + (p[18] ? 28'sd255 : 28'sd0)) >>> 8;
      end
      return base + quo[7:0];
   endfunction

   always_comb begin
      mul_in.kind = head_item.kind;
      mul_in.dest = head_item.dest;
      if (head_item.kind == KIND_MIX) begin
         mul_in.base_r = cfg.bg_color[23:16];
         mul_in.base_g = cfg.bg_color[15:8];
         mul_in.base_b = cfg.bg_color[7:0];
      end else begin
         mul_in.base_r = head_item.dst_r;
         mul_in.base_g = head_item.dst_g;
         mul_in.base_b = head_item.dst_b;
      end
      mul_in.prod_r = chan_mul(cfg.fg_color[23:16], mul_in.base_r, head_item.alpha);
      mul_in.prod_g = chan_mul(cfg.fg_color[15:8], mul_in.base_g, head_item.alpha);
      mul_in.prod_b = chan_mul(cfg.fg_color[7:0], mul_in.base_b, head_item.alpha);
   end

   assign ch_r = chan_fin(mul_ff.kind == KIND_BLEND, mul_ff.base_r, mul_ff.prod_r);
   assign ch_g = chan_fin(mul_ff.kind == KIND_BLEND, mul_ff.base_g, mul_ff.prod_g);
   assign ch_b = chan_fin(mul_ff.kind == KIND_BLEND, mul_ff.base_b, mul_ff.prod_b);

   always_comb begin
      case (mul_ff.kind)
         KIND_FG: begin
            we_in = 1'b1;
            px_in = pack_pixel(cfg.pixel_format, cfg.fg_color[23:16],
                               cfg.fg_color[15:8], cfg.fg_color[7:0]);
         end
         KIND_BLEND, KIND_MIX: begin
            we_in = 1'b1;
            px_in = pack_pixel(cfg.pixel_format, ch_r, ch_g, ch_b);
         end
         KIND_INVERT: begin
            we_in = 1'b1;
            px_in = (cfg.pixel_format == FormatRgb565) ?
                    {16'h0000, ~mul_ff.dest[15:0]} : ~mul_ff.dest;
         end
         default: begin
            we_in = 1'b0;
            px_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= head_valid;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      we_ff  <= we_in;
      px_ff  <= px_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_new_pixel    = px_ff;

endmodule

>>> src/alpha_template_pixel_blend.sv
// top level of the alpha template pixel blend: config registers and the three parts
// One pixel transaction per clock: a pixel is taken whenever start is high and busy
// is low. It is written into the queue, passes the multiply register and then the
// result register, and its result strobes on rsp_valid for a single cycle. The back
// end drains the queue every cycle because results cannot be held off, so the
// two-entry queue never holds more than one pixel and busy never rises. Each pixel
// yields exactly one result; rsp_new_pixel is zero whenever rsp_write_enable is
// low. Configuration writes are always taken (csr_ready is tied high) and should
// only be made with no pixel in flight.
module alpha_template_pixel_blend (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [7:0]                             req_alpha,
   input  logic [31:0]                            req_dest_pixel,
   output logic                                   rsp_valid,
   output logic                                   rsp_write_enable,
   output logic [31:0]                            rsp_new_pixel,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [atpb_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [atpb_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import atpb_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     queue_full;
   logic     queue_not_empty;
   logic     push;
   logic     pop;
   item_type push_item;
   item_type head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            RegDrawMode:    cfg_in.draw_mode    = csr_wdata[1:0];
            RegInvertAlpha: cfg_in.invert_alpha = csr_wdata[0];
            RegFgColor:     cfg_in.fg_color     = csr_wdata[23:0];
            RegBgColor:     cfg_in.bg_color     = csr_wdata[23:0];
            RegPixelFormat: cfg_in.pixel_format = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atpb_front u_front (
      .start          (start),
      .queue_full     (queue_full),
      .req_alpha      (req_alpha),
      .req_dest_pixel (req_dest_pixel),
      .cfg            (cfg_ff),
      .busy           (busy),
      .push           (push),
      .push_item      (push_item)
   );

   atpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   atpb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (queue_not_empty),
      .head_item        (head_item),
      .cfg              (cfg_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_write_enable (rsp_write_enable),
      .rsp_new_pixel    (rsp_new_pixel)
   );

endmodule

>>> test/tb_alpha_template_pixel_blend.sv
// testbench for the alpha template pixel blend: directed and random pixels checked against a predictor
module tb_alpha_template_pixel_blend;
   import atpb_pkg::*;

   localparam logic [1:0] ModeUnused = 2'd3;
   localparam logic [CsrIndexWidth-1:0] RegSpareLow  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegSpareHigh = 3'd7;
   localparam int StallLimit   = 1000;
   localparam int MaxReported  = 10;
   localparam int IdlePercent  = 26;

   typedef struct packed {
      logic        write_enable;
      logic [31:0] new_pixel;
   } pixel_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [7:0]               req_alpha;
   logic [31:0]              req_dest_pixel;
   logic                     rsp_valid;
   logic                     rsp_write_enable;
   logic [31:0]              rsp_new_pixel;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   // shadow copy of the block configuration
   logic [1:0]  cfg_draw_mode;
   logic        cfg_invert_alpha;
   logic [23:0] cfg_fg_color;
   logic [23:0] cfg_bg_color;
   logic        cfg_pixel_format;

   pixel_result_type expected_pixels[$];
   pixel_result_type rsp_want;
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   bit               idle_on = 1'b1;

   alpha_template_pixel_blend u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_alpha        (req_alpha),
      .req_dest_pixel   (req_dest_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_write_enable (rsp_write_enable),
      .rsp_new_pixel    (rsp_new_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] blend_channel(logic [7:0] a, logic [7:0] dst, logic [7:0] fg);
      int a_i, dst_i, fg_i, scaled;
      logic [7:0] res;
      a_i = int'(a);
      dst_i = int'(dst);
      fg_i = int'(fg);
      // rounded a*(fg-dst)*257/65536, floor after adding half
      scaled = a_i * (fg_i - dst_i) * 257 + 32768;
      res = 8'(dst_i + (scaled >>> 16));
      return res;
   endfunction

   function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] bg, logic [7:0] fg);
      int a_i, bg_i, fg_i;
      logic [7:0] res;
      a_i = int'(a);
      bg_i = int'(bg);
      fg_i = int'(fg);
      // integer division truncates toward zero
      res = 8'(bg_i + ((fg_i - bg_i) * a_i) / 256);
      return res;
   endfunction

   function automatic logic [31:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (cfg_pixel_format == FormatRgb565) return {16'h0000, r[7:3], g[7:2], b[7:3]};
      return {8'h00, r, g, b};
   endfunction

   function automatic pixel_result_type blend_pixel(logic [7:0] alpha, logic [31:0] dest);
      pixel_result_type res;
      logic [7:0] a, dr, dg, db;
      res.write_enable = 1'b0;
      res.new_pixel = 32'h0;
      a = cfg_invert_alpha ? (alpha ^ 8'hff) : alpha;
      if (cfg_pixel_format == FormatRgb565) begin
         dr = {dest[15:11], 3'b000};
         dg = {dest[10:5], 2'b00};
         db = {dest[4:0], 3'b000};
      end else begin
         dr = dest[23:16];
         dg = dest[15:8];
         db = dest[7:0];
      end
      case (cfg_draw_mode)
         ModeTransparent: begin
            if (a == 8'hff) begin
               res.write_enable = 1'b1;
               res.new_pixel = pack_rgb(cfg_fg_color[23:16], cfg_fg_color[15:8],
                                        cfg_fg_color[7:0]);
            end else if (a != 8'h00) begin
               res.write_enable = 1'b1;
               res.new_pixel = pack_rgb(blend_channel(a, dr, cfg_fg_color[23:16]),
                                        blend_channel(a, dg, cfg_fg_color[15:8]),
                                        blend_channel(a, db, cfg_fg_color[7:0]));
            end
         end
         ModeInvert: begin
            if (a >= 8'h80) begin
               res.write_enable = 1'b1;
               res.new_pixel = (cfg_pixel_format == FormatRgb565) ?
                               {16'h0000, ~dest[15:0]} : ~dest;
            end
         end
         ModeOpaque: begin
            res.write_enable = 1'b1;
            res.new_pixel = pack_rgb(mix_channel(a, cfg_bg_color[23:16], cfg_fg_color[23:16]),
                                     mix_channel(a, cfg_bg_color[15:8], cfg_fg_color[15:8]),
                                     mix_channel(a, cfg_bg_color[7:0], cfg_fg_color[7:0]));
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void apply_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] data);
      case (idx)
         RegDrawMode:    cfg_draw_mode = data[1:0];
         RegInvertAlpha: cfg_invert_alpha = data[0];
         RegFgColor:     cfg_fg_color = data[23:0];
         RegBgColor:     cfg_bg_color = data[23:0];
         RegPixelFormat: cfg_pixel_format = data[0];
         default: ;
      endcase
   endfunction

   // leaves csr_valid high so back-to-back writes never toggle it in one step
   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   task automatic configure(logic [1:0] mode, logic inv, logic [23:0] fg, logic [23:0] bg,
                            logic fmt);
      logic [31:0] junk;
      junk = $urandom & 32'hff000000;
      write_csr(RegDrawMode, ((junk | 32'h00fffffc) & ~32'h3) | 32'(mode));
      write_csr(RegInvertAlpha, ($urandom & ~32'h1) | 32'(inv));
      write_csr(RegFgColor, junk | 32'(fg));
      write_csr(RegBgColor, ($urandom & 32'hff000000) | 32'(bg));
      write_csr(RegPixelFormat, ($urandom & ~32'h1) | 32'(fmt));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(logic [7:0] alpha, logic [31:0] dest);
      @(negedge clock);
      // each cycle idles with the same odds, so gaps come in random lengths
      while (idle_on && $urandom_range(0, 99) < IdlePercent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_alpha <= alpha;
      req_dest_pixel <= dest;
      do @(posedge clock); while (busy);
      expected_pixels.push_back(blend_pixel(alpha, dest));
   endtask

   // stop sending and let every pixel in flight come back
   task automatic settle_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] random_alpha();
      logic [7:0] corners[6] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
      if ($urandom_range(0, 99) < 30) return corners[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [31:0] random_dest();
      case ($urandom_range(0, 9))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] random_color();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom_range(0, 24'hffffff));
      endcase
   endfunction

   task automatic test_reset_defaults();
      // registers are untouched: transparent mode, black foreground, xrgb8888
      send_pixel(8'h00, 32'h12345678);
      send_pixel(8'hff, 32'hffffffff);
      send_pixel(8'h80, 32'hffffffff);
   endtask

   task automatic test_transparent_blend();
      settle_pipeline();
      configure(ModeTransparent, 1'b0, 24'hffffff, 24'h000000, FormatXrgb8888);
      send_pixel(8'h00, 32'hffffffff);
      send_pixel(8'h01, 32'h00000000);
      send_pixel(8'h7f, 32'hff000000);
      send_pixel(8'hfe, 32'h00808080);
      send_pixel(8'hff, 32'h00000000);
      settle_pipeline();
      configure(ModeTransparent, 1'b1, 24'h000000, 24'hffffff, FormatRgb565);
      send_pixel(8'h00, 32'hffffffff);
      send_pixel(8'hff, 32'h0000ffff);
      send_pixel(8'h80, 32'habcdffff);
   endtask

   task automatic test_invert_mode();
      settle_pipeline();
      configure(ModeInvert, 1'b0, 24'h123456, 24'h654321, FormatXrgb8888);
      send_pixel(8'h7f, 32'h12345678);
      send_pixel(8'h80, 32'h12345678);
      send_pixel(8'hff, 32'h00000000);
      settle_pipeline();
      configure(ModeInvert, 1'b1, 24'h123456, 24'h654321, FormatRgb565);
      send_pixel(8'h00, 32'hffff0000);
      send_pixel(8'h80, 32'h5555aaaa);
   endtask

   task automatic test_opaque_mix();
      settle_pipeline();
      configure(ModeOpaque, 1'b0, 24'hffffff, 24'h000000, FormatXrgb8888);
      send_pixel(8'h00, 32'hffffffff);
      send_pixel(8'hff, 32'h00000000);
      settle_pipeline();
      configure(ModeOpaque, 1'b0, 24'h00ff00, 24'hff00ff, FormatRgb565);
      send_pixel(8'h80, 32'h00000000);
      send_pixel(8'h01, 32'hffffffff);
   endtask

   task automatic test_unused_codes();
      logic [CsrIndexWidth-1:0] idx;
      settle_pipeline();
      configure(ModeUnused, 1'b0, 24'hffffff, 24'hffffff, FormatXrgb8888);
      // spare register indexes must leave the configuration alone
      idx = RegSpareLow;
      forever begin
         write_csr(idx, $urandom);
         if (idx == RegSpareHigh) break;
         idx++;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      send_pixel(8'hff, 32'hffffffff);
      send_pixel(8'h80, 32'h00000000);
   endtask

   task automatic test_random_stream();
      int items;
      for (int phase = 0; phase < 22; phase++) begin
         settle_pipeline();
         if (phase == 0) begin
            configure(ModeTransparent, 1'b0, 24'h000000, 24'h000000, FormatXrgb8888);
         end else if (phase == 1) begin
            configure(ModeOpaque, 1'b1, 24'hffffff, 24'hffffff, FormatRgb565);
         end else begin
            configure(($urandom_range(0, 9) == 0) ? ModeUnused : 2'($urandom_range(0, 2)),
                      1'($urandom_range(0, 1)), random_color(), random_color(),
                      1'($urandom_range(0, 1)));
         end
         idle_on = (phase != 10);
         items = (phase == 10) ? 150 : 50;
         for (int i = 0; i < items; i++) begin
            if (phase == 5 && i == 25) settle_pipeline();
            send_pixel(random_alpha(), random_dest());
         end
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
               $display("unexpected result: write_enable=%0b new_pixel=%08h",
                        rsp_write_enable, rsp_new_pixel);
         end else begin
            rsp_want = expected_pixels.pop_front();
            if (rsp_write_enable !== rsp_want.write_enable ||
                rsp_new_pixel !== rsp_want.new_pixel) begin
               mismatch_count++;
               if (mismatch_count <= MaxReported)
                  $display("mismatch: write_enable exp %0b got %0b, new_pixel exp %08h got %08h",
                           rsp_want.write_enable, rsp_write_enable,
                           rsp_want.new_pixel, rsp_new_pixel);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_alpha = 8'h00;
      req_dest_pixel = 32'h0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_draw_mode = ModeTransparent;
      cfg_invert_alpha = 1'b0;
      cfg_fg_color = 24'h0;
      cfg_bg_color = 24'h0;
      cfg_pixel_format = FormatXrgb8888;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_transparent_blend();
      test_invert_mode();
      test_opaque_mix();
      test_unused_codes();
      test_random_stream();

      settle_pipeline();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> alpha_template_pixel_blend.f
src/atpb_pkg.sv
src/atpb_front.sv
src/atpb_queue.sv
src/atpb_back.sv
src/alpha_template_pixel_blend.sv
test/tb_alpha_template_pixel_blend.sv
